// ===== rtl/ksum_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ksum_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0]       status_t;

  localparam status_t ST_ZERO   = 3'd0;
  localparam status_t ST_INSERT = 3'd1;
  localparam status_t ST_UPDATE = 3'd2;
  localparam status_t ST_ERASE  = 3'd3;
  localparam status_t ST_FULL   = 3'd4;
  localparam status_t ST_LOOKUP = 3'd5;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic signed [31:0] SUM_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN   = 32'sh8000_0000;
  localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] TOTAL_MIN = 48'sh8000_0000_0000;

  // search token that walks the row of cells
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic               hit;
    idx_t               hit_idx;
    logic signed [31:0] hit_sum;
    logic               free_ok;
    idx_t               free_idx;
  } probe_t;

  // write broadcast to all cells, taken by the addressed one
  typedef struct packed {
    logic               en;
    idx_t               idx;
    logic               used;
    logic signed [31:0] key;
    logic signed [31:0] sum;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/ksum_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ksum_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] key;
  logic signed [31:0] amount;

  modport source (output valid, mode, key, amount, input ready);
  modport sink (input valid, mode, key, amount, output ready);
endinterface

interface ksum_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_sum;
  logic               found;
  logic signed [47:0] grand_total;
  logic [2:0]         status;

  modport source (output valid, entry_sum, found, grand_total, status, input ready);
  modport sink (input valid, entry_sum, found, grand_total, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ksum_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ksum_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  ksum_pkg::idx_t      cell_idx,
  input  ksum_pkg::probe_t    probe_in,
  input  ksum_pkg::wr_t       wr,
  output ksum_pkg::probe_t    probe_out
);
  import ksum_pkg::*;

  logic               used;
  logic signed [31:0] key;
  logic signed [31:0] sum;
  probe_t             probe_next;

  always_comb begin
    probe_next = probe_in;
    if (used && key == probe_in.key) begin
      probe_next.hit     = 1'b1;
      probe_next.hit_idx = cell_idx;
      probe_next.hit_sum = sum;
    end
    // first free cell along the row is the lowest free slot
    if (!used && !probe_in.free_ok) begin
      probe_next.free_ok  = 1'b1;
      probe_next.free_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used            <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      probe_out <= probe_next;
      if (wr.en && wr.idx == cell_idx) begin
        used <= wr.used;
        key  <= wr.key;
        sum  <= wr.sum;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/keyed_sum_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  fields
// req      in   mode, key, amount
// rsp      out  entry_sum, found, grand_total, status
//
// one transaction at a time: a search token walks the row of ENTRIES cells,
// one cell per cycle, then S_CALC decides the result and S_TOT updates the total;
// the next request is taken as soon as the previous result sits in the
// output register, even if rsp is stalled
// rst (synchronous) frees every slot and clears the running total

module keyed_sum_table_unit (
  input  wire        clk,
  input  wire        rst,
  ksum_req_if.sink   req,
  ksum_rsp_if.source rsp
);
  import ksum_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CALC, S_TOT, S_DONE} state_t;

  state_t             state;
  logic               mode;
  logic signed [31:0] key;
  logic signed [31:0] amount;
  logic               hit;
  idx_t               hit_idx;
  logic signed [31:0] hit_sum;
  logic               free_ok;
  idx_t               free_idx;

  logic signed [47:0] total;
  logic signed [33:0] delta;
  logic signed [31:0] res_sum;
  status_t            res_status;
  wr_t                wr;

  logic               rsp_valid;
  logic signed [31:0] rsp_sum;
  logic               rsp_found;
  logic signed [47:0] rsp_total;
  status_t            rsp_status;

  probe_t             probe [ENTRIES+1];
  logic [ENTRIES-1:0] probe_live;

  logic               accept;
  logic               out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;

  always_comb begin
    probe[0]          = '0;
    probe[0].valid    = accept;
    probe[0].key      = req.key;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ksum_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (idx_t'(i)),
      .probe_in  (probe[i]),
      .wr        (wr),
      .probe_out (probe[i+1])
    );
    assign probe_live[i] = probe[i+1].valid;
  end

  // decision for the item once the search is done
  logic signed [32:0] wide;
  logic signed [31:0] sat_sum;
  logic signed [33:0] delta_next;
  logic signed [31:0] sum_next;
  status_t            status_next;
  wr_t                wr_next;

  always_comb begin
    wide = 33'(hit_sum) + 33'(amount);
    if (wide[32] != wide[31]) begin
      sat_sum = wide[32] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = wide[31:0];
    end
    delta_next   = '0;
    sum_next     = '0;
    wr_next      = '0;
    wr_next.key  = key;
    if (mode == MODE_LOOKUP || amount == '0) begin
      status_next = (mode == MODE_LOOKUP) ? ST_LOOKUP : ST_ZERO;
      sum_next    = hit ? hit_sum : '0;
    end else if (!hit) begin
      if (!free_ok) begin
        status_next = ST_FULL;
      end else begin
        status_next  = ST_INSERT;
        sum_next     = amount;
        delta_next   = 34'(amount);
        wr_next.en   = 1'b1;
        wr_next.idx  = free_idx;
        wr_next.used = 1'b1;
        wr_next.sum  = amount;
      end
    end else if (wide == '0) begin
      status_next  = ST_ERASE;
      delta_next   = 34'sd0 - 34'(hit_sum);
      wr_next.en   = 1'b1;
      wr_next.idx  = hit_idx;
      wr_next.used = 1'b0;
    end else begin
      status_next  = ST_UPDATE;
      sum_next     = sat_sum;
      delta_next   = 34'(sat_sum) - 34'(hit_sum);
      wr_next.en   = 1'b1;
      wr_next.idx  = hit_idx;
      wr_next.used = 1'b1;
      wr_next.sum  = sat_sum;
    end
  end

  logic signed [48:0] total_wide;
  logic signed [47:0] total_next;

  always_comb begin
    total_wide = 49'(total) + 49'(delta);
    if (total_wide[48] != total_wide[47]) begin
      total_next = total_wide[48] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_next = total_wide[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      wr        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // slot write lasts exactly one cycle, in S_TOT
      wr        <= (state == S_CALC) ? wr_next : '0;
      rsp_valid <= (state == S_DONE && out_free) || (rsp_valid && !rsp.ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode   <= req.mode;
            key    <= req.key;
            amount <= req.amount;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (probe[ENTRIES].valid) begin
            hit      <= probe[ENTRIES].hit;
            hit_idx  <= probe[ENTRIES].hit_idx;
            hit_sum  <= probe[ENTRIES].hit_sum;
            free_ok  <= probe[ENTRIES].free_ok;
            free_idx <= probe[ENTRIES].free_idx;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          delta      <= delta_next;
          res_sum    <= sum_next;
          res_status <= status_next;
          state      <= S_TOT;
        end
        S_TOT: begin
          total <= total_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp_sum    <= res_sum;
            rsp_found  <= hit;
            rsp_total  <= total;
            rsp_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.entry_sum   = rsp_sum;
  assign rsp.found       = rsp_found;
  assign rsp.grand_total = rsp_total;
  assign rsp.status      = rsp_status;

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(probe_live) <= 1)
    else $error("more than one search token in the row");

  a_token_end: assert property (@(posedge clk) disable iff (rst)
    probe[ENTRIES].valid |-> state == S_SCAN)
    else $error("search finished outside scan");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state == S_TOT && !(|probe_live))
    else $error("slot write while a search is running");

  a_insert_new: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_INSERT |-> !rsp_found)
    else $error("insert reported for a present key");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_sum == '0 && !rsp_found)
    else $error("dropped item reports a sum");

endmodule

`default_nettype wire
